FILE: sv/swut_pkg.sv
// ----------------------------------------------------------------------------
// swut_pkg
// Shared types and constants for the single-wire UART transceiver.
// ----------------------------------------------------------------------------
package swut_pkg;

   // field widths
   localparam int FUNC_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // default width of the tick counter
   localparam int TICK_BITS_DEFAULT = 16;

   // entries in the front-to-back queue
   localparam int QUEUE_DEPTH = 2;

   // register reset values
   localparam logic [CSR_W-1:0] BIT_TICKS_RST     = 16'd52;
   localparam logic [CSR_W-1:0] HALF_BIT_TICKS_RST = 16'd26;
   localparam logic [CSR_W-1:0] RX_TIMEOUT_RST    = 16'd50000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_TICKS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_BIT_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_TIMEOUT     = 2'd2;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SEND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RECV = 2'd2;

   // receive status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FALSE_START = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_STOP     = 2'd3;

   // classified command
   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_SEND,
      CMD_RECV
   } cmd_type;

   // one queued tick word
   typedef struct packed {
      cmd_type            cmd;
      logic [BYTE_W-1:0]  tx_byte;
      logic               tx_last;
      logic               line_in;
   } tick_word_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic          valid;
      tick_word_type word;
   } queue_head_type;

endpackage

FILE: sv/single_wire_uart_transceiver_top.sv
// ----------------------------------------------------------------------------
// single_wire_uart_transceiver_top
// Half-duplex single-wire 8N1 UART, advanced by one tick word per request.
// ----------------------------------------------------------------------------
// Each request word is one tick of the bit timing base and yields exactly one
// response word. The block takes one request word per clock cycle while
// req_stall is low: the front end pushes it into a two-word queue, and the
// engine pops it from the queue head into the response register, so each word
// is registered in the queue and then in the response register before it
// appears on the response side. A stalled response register backs up the
// queue, and request stall rises once both queue slots hold words.
// Configuration registers take effect at the next tick processed.
module single_wire_uart_transceiver_top #(
   parameter int TICK_COUNTER_BITS = swut_pkg::TICK_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [swut_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [swut_pkg::CSR_W-1:0]     csr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [swut_pkg::FUNC_W-1:0]    req_func,
   input  logic [swut_pkg::BYTE_W-1:0]    req_tx_byte,
   input  logic                           req_tx_last,
   input  logic                           req_line_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_line_out,
   output logic                           rsp_line_drive,
   output logic                           rsp_rx_valid,
   output logic [swut_pkg::BYTE_W-1:0]    rsp_rx_byte,
   output logic [swut_pkg::STATUS_W-1:0]  rsp_rx_status,
   output logic                           rsp_busy_res,
   output logic                           rsp_tx_done
);
   import swut_pkg::*;

   queue_head_type head;
   logic           pop;

   // front end: decode and queue
   swut_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_tx_byte (req_tx_byte),
      .req_tx_last (req_tx_last),
      .req_line_in (req_line_in),
      .pop         (pop),
      .head        (head)
   );

   // back end: bit timing engine
   swut_engine #(
      .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_line_out   (rsp_line_out),
      .rsp_line_drive (rsp_line_drive),
      .rsp_rx_valid   (rsp_rx_valid),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_rx_status  (rsp_rx_status),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_tx_done    (rsp_tx_done)
   );

endmodule

FILE: sv/swut_queue.sv
// ----------------------------------------------------------------------------
// swut_queue
// Short queue of classified tick words between the front and the engine.
// ----------------------------------------------------------------------------
module swut_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  swut_pkg::tick_word_type push_word,
   output logic                    full,
   input  logic                    pop,
   output swut_pkg::queue_head_type head
);
   import swut_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tick_word_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_pop = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.word  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

FILE: sv/swut_front.sv
// ----------------------------------------------------------------------------
// swut_front
// Accepts request words, decodes the function code and queues them.
// ----------------------------------------------------------------------------
module swut_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [swut_pkg::FUNC_W-1:0] req_func,
   input  logic [swut_pkg::BYTE_W-1:0] req_tx_byte,
   input  logic                        req_tx_last,
   input  logic                        req_line_in,
   input  logic                        pop,
   output swut_pkg::queue_head_type    head
);
   import swut_pkg::*;

   tick_word_type word;
   logic          full;
   logic          push;

   // decode function; unused code counts as a plain tick
   always_comb begin
      unique case (req_func)
         FUNC_SEND: word.cmd = CMD_SEND;
         FUNC_RECV: word.cmd = CMD_RECV;
         default:   word.cmd = CMD_TICK;
      endcase
      word.tx_byte = req_tx_byte;
      word.tx_last = req_tx_last;
      word.line_in = req_line_in;
   end

   assign req_stall = full;
   assign push      = req_valid && !full;

   swut_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (word),
      .full      (full),
      .pop       (pop),
      .head      (head)
   );

endmodule

FILE: sv/swut_engine.sv
// ----------------------------------------------------------------------------
// swut_engine
// Bit timing engine: one tick word per cycle unless the result stalls, registered result word.
// ----------------------------------------------------------------------------
module swut_engine #(
   parameter int TICK_COUNTER_BITS = swut_pkg::TICK_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [swut_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [swut_pkg::CSR_W-1:0]     csr_data,
   input  swut_pkg::queue_head_type       head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_line_out,
   output logic                           rsp_line_drive,
   output logic                           rsp_rx_valid,
   output logic [swut_pkg::BYTE_W-1:0]    rsp_rx_byte,
   output logic [swut_pkg::STATUS_W-1:0]  rsp_rx_status,
   output logic                           rsp_busy_res,
   output logic                           rsp_tx_done
);
   import swut_pkg::*;

   localparam int CNT_W = TICK_COUNTER_BITS;
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_TX,
      MODE_RX_WAIT,
      MODE_RX_BITS
   } mode_type;

   // configuration registers
   logic [CSR_W-1:0] bit_ticks_ff, half_bit_ticks_ff, rx_timeout_ff;

   // engine state
   mode_type          mode_ff, mode_in, mode_cur;
   logic [3:0]        bit_index_ff, bit_index_in, bit_index_cur;
   logic [CNT_W-1:0]  tick_count_ff, tick_count_in, cnt_base, cnt_next;
   logic [BYTE_W-1:0] shift_byte_ff, shift_byte_in, shift_cur;
   logic              release_ff, release_in, release_cur;
   logic              driving_ff, driving_in, driving_cur;
   logic              started_ff, started_in, started_cur;

   // result word register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              line_out_ff, line_out_in;
   logic              line_drive_ff, line_drive_in;
   logic              rx_valid_ff, rx_valid_in;
   logic [BYTE_W-1:0] rx_byte_ff, rx_byte_in;
   logic [STATUS_W-1:0] rx_status_ff, rx_status_in;
   logic              busy_ff, busy_in;
   logic              tx_done_ff, tx_done_in;

   logic [CSR_W-1:0]  thr;
   logic              reached;
   logic [3:0]        bit_pos;
   logic              lin;

   assign pop = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign lin = head.word.line_in;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff      <= BIT_TICKS_RST;
         half_bit_ticks_ff <= HALF_BIT_TICKS_RST;
         rx_timeout_ff     <= RX_TIMEOUT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BIT_TICKS:      bit_ticks_ff      <= csr_data;
            CSR_HALF_BIT_TICKS: half_bit_ticks_ff <= csr_data;
            CSR_RX_TIMEOUT:     rx_timeout_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // command start while idle
   always_comb begin
      mode_cur      = mode_ff;
      bit_index_cur = bit_index_ff;
      cnt_base      = tick_count_ff;
      shift_cur     = shift_byte_ff;
      release_cur   = release_ff;
      driving_cur   = driving_ff;
      started_cur   = started_ff;
      if (mode_ff == MODE_IDLE) begin
         if (head.word.cmd == CMD_SEND) begin
            mode_cur      = MODE_TX;
            driving_cur   = 1'b1;
            bit_index_cur = '0;
            cnt_base      = '0;
            shift_cur     = head.word.tx_byte;
            release_cur   = head.word.tx_last;
         end else if (head.word.cmd == CMD_RECV) begin
            mode_cur      = MODE_RX_WAIT;
            driving_cur   = 1'b0;
            bit_index_cur = '0;
            cnt_base      = '0;
            shift_cur     = '0;
            started_cur   = 1'b0;
         end
      end
   end

   // interval counter: saturating increment and compare against the threshold
   always_comb begin
      unique case (mode_cur)
         MODE_RX_WAIT: thr = rx_timeout_ff;
         MODE_RX_BITS: thr = started_cur ? bit_ticks_ff : half_bit_ticks_ff;
         default:      thr = bit_ticks_ff;
      endcase
      cnt_next = (cnt_base != '1) ? cnt_base + 1'b1 : cnt_base;
      reached  = (CMP_W'(cnt_next) >= CMP_W'(thr)) || (cnt_next == '1);
   end

   assign bit_pos = bit_index_cur - 4'd1;

   // one tick of the bit engine
   always_comb begin
      mode_in       = mode_cur;
      bit_index_in  = bit_index_cur;
      tick_count_in = cnt_base;
      shift_byte_in = shift_cur;
      release_in    = release_cur;
      driving_in    = driving_cur;
      started_in    = started_cur;
      line_out_in   = 1'b1;
      rx_valid_in   = 1'b0;
      rx_byte_in    = '0;
      rx_status_in  = ST_OK;
      tx_done_in    = 1'b0;
      unique case (mode_cur)
         MODE_TX: begin
            if (bit_index_cur == 4'd0) begin
               line_out_in = 1'b0;
            end else if (bit_index_cur <= 4'd8) begin
               line_out_in = shift_cur[bit_pos[2:0]];
            end
            tick_count_in = reached ? '0 : cnt_next;
            if (reached) begin
               if (bit_index_cur >= 4'd9) begin
                  tx_done_in   = 1'b1;
                  mode_in      = MODE_IDLE;
                  bit_index_in = '0;
                  if (release_cur) begin
                     driving_in = 1'b0;
                  end
               end else begin
                  bit_index_in = bit_index_cur + 4'd1;
               end
            end
         end
         MODE_RX_WAIT: begin
            if (!lin) begin
               mode_in       = MODE_RX_BITS;
               tick_count_in = '0;
               started_in    = 1'b0;
            end else if (reached) begin
               mode_in       = MODE_IDLE;
               tick_count_in = '0;
               rx_valid_in   = 1'b1;
               rx_status_in  = ST_TIMEOUT;
            end else begin
               tick_count_in = cnt_next;
            end
         end
         MODE_RX_BITS: begin
            tick_count_in = reached ? '0 : cnt_next;
            if (reached) begin
               if (!started_cur) begin
                  if (lin) begin
                     mode_in      = MODE_IDLE;
                     rx_valid_in  = 1'b1;
                     rx_status_in = ST_FALSE_START;
                  end else begin
                     started_in   = 1'b1;
                     bit_index_in = '0;
                  end
               end else if (bit_index_cur < 4'd8) begin
                  shift_byte_in = {lin, shift_cur[BYTE_W-1:1]};
                  bit_index_in  = bit_index_cur + 4'd1;
               end else begin
                  mode_in      = MODE_IDLE;
                  bit_index_in = '0;
                  rx_valid_in  = 1'b1;
                  if (lin) begin
                     rx_byte_in = shift_cur;
                  end else begin
                     rx_status_in = ST_NO_STOP;
                  end
               end
            end
         end
         default: ;
      endcase
      line_drive_in = driving_cur;
      if (!driving_cur) begin
         line_out_in = 1'b1;
      end
      busy_in      = (mode_in != MODE_IDLE);
      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   end

   // engine state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         bit_index_ff  <= '0;
         tick_count_ff <= '0;
         shift_byte_ff <= '0;
         release_ff    <= 1'b0;
         driving_ff    <= 1'b0;
         started_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            mode_ff       <= mode_in;
            bit_index_ff  <= bit_index_in;
            tick_count_ff <= tick_count_in;
            shift_byte_ff <= shift_byte_in;
            release_ff    <= release_in;
            driving_ff    <= driving_in;
            started_ff    <= started_in;
         end
      end
   end

   // result word payload
   always_ff @(posedge clock) begin
      if (pop) begin
         line_out_ff   <= line_out_in;
         line_drive_ff <= line_drive_in;
         rx_valid_ff   <= rx_valid_in;
         rx_byte_ff    <= rx_byte_in;
         rx_status_ff  <= rx_status_in;
         busy_ff       <= busy_in;
         tx_done_ff    <= tx_done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_out   = line_out_ff;
   assign rsp_line_drive = line_drive_ff;
   assign rsp_rx_valid   = rx_valid_ff;
   assign rsp_rx_byte    = rx_byte_ff;
   assign rsp_rx_status  = rx_status_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_tx_done    = tx_done_ff;

endmodule
